[design/ubxfp_pkg.sv]
// ----------------------------------------------------------------------------
// ubxfp_pkg
// Shared types and constants for the UBX frame parser: parse phases, match
// configuration, result word layout and configuration register indexes.
// ----------------------------------------------------------------------------
package ubxfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // reset values of the match registers
    localparam logic [7:0]  MATCH_CLASS_RST  = 8'd1;
    localparam logic [7:0]  MATCH_ID_RST     = 8'd7;
    localparam logic [15:0] MATCH_LENGTH_RST = 16'd92;

    // configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CLASS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ID     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LENGTH = 2'd2;

    // result stream geometry
    localparam int OUT_DATA_W = 80;

    typedef enum logic [3:0] {
        PH_HUNT1   = 4'd0,
        PH_HUNT2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_HI   = 4'd7,
        PH_CK_LO   = 4'd8
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0]  match_class;
        logic [7:0]  match_id;
        logic [15:0] match_length;
    } match_cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] payload_offset;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic [15:0] checksum_word;
        logic        accepted;
    } result_t;

endpackage

[design/ubxfp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ubxfp_cfg_regs
// Match registers for class, id and payload length, written over the
// configuration channel; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ubxfp_cfg_regs
    import ubxfp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output match_cfg_t             match_cfg
);

    match_cfg_t cfg_reg;

    // always ready to take a word
    assign cfg_ready = 1'b1;
    assign match_cfg = cfg_reg;

    // register write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_class  <= MATCH_CLASS_RST;
            cfg_reg.match_id     <= MATCH_ID_RST;
            cfg_reg.match_length <= MATCH_LENGTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_CLASS:  cfg_reg.match_class  <= cfg_data[7:0];
                CFG_IDX_ID:     cfg_reg.match_id     <= cfg_data[7:0];
                CFG_IDX_LENGTH: cfg_reg.match_length <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[design/ubxfp_parser.sv]
// ----------------------------------------------------------------------------
// ubxfp_parser
// Input byte register and frame state machine. Each held byte advances the
// parse by one step and may produce one payload or frame-end result.
// ----------------------------------------------------------------------------
module ubxfp_parser
    import ubxfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  match_cfg_t match_cfg,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic        hold_valid_reg;
    logic [7:0]  hold_byte_reg;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] seen_reg, seen_next;
    logic [15:0] checksum_reg, checksum_next;
    logic        emit_phase;
    logic        advance;
    logic [15:0] seen_inc;
    logic [15:0] length_full;

    // held byte moves on unless it must emit and the result slot is full
    assign emit_phase = (phase_reg == PH_PAYLOAD) || (phase_reg == PH_CK_LO);
    assign advance    = hold_valid_reg && (!emit_phase || res_ready);
    assign in_ready   = !hold_valid_reg || advance;
    assign res_valid  = hold_valid_reg && emit_phase;

    assign seen_inc    = seen_reg + 16'd1;
    assign length_full = {hold_byte_reg, length_reg[7:0]};

    // input byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (in_ready) begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hold_byte_reg <= in_byte;
        end
    end

    // phase and frame header state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT1;
            class_reg    <= '0;
            id_reg       <= '0;
            length_reg   <= '0;
            seen_reg     <= '0;
            checksum_reg <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            class_reg    <= class_next;
            id_reg       <= id_next;
            length_reg   <= length_next;
            seen_reg     <= seen_next;
            checksum_reg <= checksum_next;
        end
    end

    // next state and result fields
    always_comb begin
        phase_next    = phase_reg;
        class_next    = class_reg;
        id_next       = id_reg;
        length_next   = length_reg;
        seen_next     = seen_reg;
        checksum_next = checksum_reg;

        res.kind           = KIND_PAYLOAD;
        res.payload_offset = '0;
        res.payload_byte   = '0;
        res.frame_class    = class_reg;
        res.frame_id       = id_reg;
        res.frame_length   = length_reg;
        res.checksum_word  = '0;
        res.accepted       = 1'b0;

        case (phase_reg)
            PH_HUNT2: begin
                if (hold_byte_reg == SYNC_SECOND) begin
                    phase_next = PH_CLASS;
                end else if (hold_byte_reg != SYNC_FIRST) begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_CLASS: begin
                class_next = hold_byte_reg;
                phase_next = PH_ID;
            end
            PH_ID: begin
                id_next    = hold_byte_reg;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = {8'd0, hold_byte_reg};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = length_full;
                seen_next   = '0;
                phase_next  = (length_full == 16'd0) ? PH_CK_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                res.payload_offset = seen_reg;
                res.payload_byte   = hold_byte_reg;
                seen_next          = seen_inc;
                if (seen_inc >= length_reg) begin
                    phase_next = PH_CK_HI;
                end
            end
            PH_CK_HI: begin
                checksum_next = {hold_byte_reg, 8'd0};
                phase_next    = PH_CK_LO;
            end
            PH_CK_LO: begin
                checksum_next     = {checksum_reg[15:8], hold_byte_reg};
                res.kind          = KIND_FRAME_END;
                res.checksum_word = {checksum_reg[15:8], hold_byte_reg};
                res.accepted      = (class_reg == match_cfg.match_class) &&
                                    (id_reg == match_cfg.match_id) &&
                                    (length_reg == match_cfg.match_length);
                phase_next        = PH_HUNT1;
            end
            default: begin
                phase_next = (hold_byte_reg == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

endmodule

[design/ubxfp_out_reg.sv]
// ----------------------------------------------------------------------------
// ubxfp_out_reg
// Result register in front of the master channel; it refills in the same
// cycle that the downstream side takes the held word.
// ----------------------------------------------------------------------------
module ubxfp_out_reg
    import ubxfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

endmodule

[design/ubx_frame_parser.sv]
// ----------------------------------------------------------------------------
// ubx_frame_parser
// UBX frame parser: finds the B5 62 sync pair, latches class, id and length,
// streams payload bytes with their offsets and reports each frame end.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one received byte per word in s_tdata.
//   m_ channel carries one result per word; m_tuser is the kind (0 payload
//   byte, 1 frame end), m_tdata holds the remaining fields.
//   cfg channel writes the match registers: index 0 class, 1 id, 2 length;
//   other indexes are ignored. cfg_ready is always high.
// Timing:
//   a byte passes an input register and then a result register before its
//   result, if any, is valid on m_. One byte is taken per cycle unless a
//   byte that needs the result slot waits behind a held word; a single
//   parse step lies between the two registers.
// Reset:
//   aresetn low clears both stages, returns the parser to hunting for the
//   first sync byte and loads class 1, id 7, length 92 as the match values.
// Stall:
//   while m_tready is low the result register holds its word; bytes that
//   make no result keep flowing, and s_tready drops once a byte that needs
//   the result slot is waiting behind the held word.
// ----------------------------------------------------------------------------
module ubx_frame_parser
    import ubxfp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] payload_offset, [23:16] payload_byte, [31:24] frame_class,
    // [39:32] frame_id, [55:40] frame_length, [71:56] checksum_word,
    // [72] accepted, [79:73] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser,   // [0] kind
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    match_cfg_t match_cfg;
    logic       res_valid;
    logic       res_ready;
    result_t    res;
    result_t    out_res;

    // match registers
    ubxfp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .match_cfg (match_cfg)
    );

    // input register and frame state machine
    ubxfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .match_cfg (match_cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register
    ubxfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack result fields, highest field first
    assign m_tuser = out_res.kind;
    assign m_tdata = {7'd0,
                      out_res.accepted,
                      out_res.checksum_word,
                      out_res.frame_length,
                      out_res.frame_id,
                      out_res.frame_class,
                      out_res.payload_byte,
                      out_res.payload_offset};

endmodule
